// ----- design/stbs_pkg.sv -----
package stbs_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W = 32;
  localparam int POS_W = 6;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  function automatic logic less_signed(input logic [DATA_W-1:0] a,
                                       input logic [DATA_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

// ----- design/stbs_table.sv -----
module stbs_table #(
  parameter int DEPTH = stbs_pkg::DEPTH_DEF,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [IW-1:0]               waddr,
  input  logic [stbs_pkg::DATA_W-1:0] wdata,
  input  logic [IW-1:0]               raddr,
  output logic [stbs_pkg::DATA_W-1:0] rdata
);
  import stbs_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/sorted_table_binary_search.sv -----
// A clear passes from idle through the done state to the done strobe.
// An insert into a table of n entries moves each larger entry up one place,
// one entry at a time through the single write port of the table memory.
// A search runs each halving step through the S_SRCH and S_SCMP states.
// One word is in work at a time; busy drops in the cycle of done, so the next
// start is accepted there. Reset clears the entry count and the control state.
module sorted_table_binary_search #(
  parameter int DEPTH = stbs_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op,
  input  logic signed [stbs_pkg::DATA_W-1:0] value,
  output logic                          done,
  output logic                          found,
  output logic [stbs_pkg::POS_W-1:0]    position,
  output logic                          status
);
  import stbs_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SHIFT = 8'b0000_0010,
    S_PLACE = 8'b0000_0100,
    S_SRCH  = 8'b0000_1000,
    S_SCMP  = 8'b0001_0000,
    S_SCHK  = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     lo, lo_next;
  logic [CW-1:0]     hi, hi_next;
  logic [CW-1:0]     mid, mid_next;
  logic [IW-1:0]     ptr, ptr_next;
  logic [DATA_W-1:0] key, key_next;
  logic              found_next, status_next;
  logic [POS_W-1:0]  position_next;
  logic              done_next;
  logic [CW+POS_W-1:0] lo_wide;

  logic              we;
  logic [IW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;

  stbs_table #(.DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy = (state != S_IDLE);
  assign lo_wide = {{POS_W{1'b0}}, lo};

  always_comb begin
    state_next = state;
    count_next = count;
    lo_next = lo;
    hi_next = hi;
    mid_next = mid;
    ptr_next = ptr;
    key_next = key;
    found_next = found;
    position_next = position;
    status_next = status;
    done_next = 1'b0;
    we = 1'b0;
    waddr = ptr;
    wdata = key;
    raddr = mid[IW-1:0];
    case (state)
      S_IDLE: begin
        if (start) begin
          key_next = value;
          found_next = 1'b0;
          position_next = '0;
          status_next = 1'b0;
          state_next = S_DONE;
          case (op)
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_INSERT: begin
              if (count == CW'(DEPTH)) begin
                status_next = 1'b1;
              end else if (count == '0) begin
                we = 1'b1;
                waddr = '0;
                wdata = value;
                count_next = CW'(1);
              end else begin
                raddr = count[IW-1:0] - IW'(1);
                ptr_next = count[IW-1:0];
                state_next = S_SHIFT;
              end
            end
            OP_SEARCH: begin
              lo_next = '0;
              hi_next = count;
              state_next = S_SRCH;
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        we = 1'b1;
        waddr = ptr;
        if (less_signed(key, rdata)) begin
          wdata = rdata;
          ptr_next = ptr - IW'(1);
          raddr = ptr - IW'(2);
          if (ptr == IW'(1)) begin
            state_next = S_PLACE;
          end
        end else begin
          wdata = key;
          count_next = count + CW'(1);
          state_next = S_DONE;
        end
      end
      S_PLACE: begin
        we = 1'b1;
        waddr = ptr;
        wdata = key;
        count_next = count + CW'(1);
        state_next = S_DONE;
      end
      S_SRCH: begin
        if (lo < hi) begin
          mid_next = lo + ((hi - lo) >> 1);
          raddr = mid_next[IW-1:0];
          state_next = S_SCMP;
        end else if (lo < count) begin
          raddr = lo[IW-1:0];
          state_next = S_SCHK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCMP: begin
        if (less_signed(rdata, key)) begin
          lo_next = mid + CW'(1);
        end else begin
          hi_next = mid;
        end
        state_next = S_SRCH;
      end
      S_SCHK: begin
        if (rdata == key) begin
          found_next = 1'b1;
          position_next = lo_wide[POS_W-1:0];
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        done_next = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done <= done_next;
    end
    lo <= lo_next;
    hi <= hi_next;
    mid <= mid_next;
    ptr <= ptr_next;
    key <= key_next;
    found <= found_next;
    position <= position_next;
    status <= status_next;
  end

endmodule

// ----- design/stbs_check.sv -----
module stbs_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic                       found,
  input logic [stbs_pkg::POS_W-1:0] position,
  input logic                       status
);

  // An accepted word always raises busy in the cycle after it is accepted.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done shown while busy");

  assert property (@(posedge clk) disable iff (rst)
      (!$past(rst) && $fell(busy)) |-> done)
    else $error("busy dropped without a result");

  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two results in a row");

  assert property (@(posedge clk) disable iff (rst)
      (done && (found || position != '0)) |-> !status)
    else $error("search result carries a dropped-insert flag");

endmodule

bind sorted_table_binary_search stbs_check u_check (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .found    (found),
  .position (position),
  .status   (status)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import stbs_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int TABLE_DEPTH = DEPTH_DEF;
  localparam int RANDOM_WORDS = 1550;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
    int                       gap_pct;
  } word_t;

  typedef struct {
    logic             found;
    logic [POS_W-1:0] position;
    logic             status;
  } result_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               op;
  logic signed [DATA_W-1:0] value;
  logic                     done;
  logic                     found;
  logic [POS_W-1:0]         position;
  logic                     status;

  word_t   pending_words[$];
  result_t expected_results[$];
  int      issued_cnt;
  int      accepted_cnt;
  int      mismatches;
  int      queued_cnt;

  logic signed [DATA_W-1:0] shadow_table[TABLE_DEPTH];
  int                       shadow_count;

  sorted_table_binary_search dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .value(value),
    .done(done),
    .found(found),
    .position(position),
    .status(status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic result_t apply_word(logic [1:0] w_op, logic signed [DATA_W-1:0] w_value);
    result_t r;
    int      at;
    r.found = 1'b0;
    r.position = '0;
    r.status = 1'b0;
    case (w_op)
      OP_CLEAR: shadow_count = 0;
      OP_INSERT: begin
        if (shadow_count >= TABLE_DEPTH) begin
          r.status = 1'b1;
        end else begin
          at = shadow_count;
          for (int i = shadow_count - 1; i >= 0; i--) begin
            if (shadow_table[i] > w_value) at = i;
          end
          for (int i = shadow_count; i > at; i--) shadow_table[i] = shadow_table[i - 1];
          shadow_table[at] = w_value;
          shadow_count++;
        end
      end
      OP_SEARCH: begin
        for (int i = shadow_count - 1; i >= 0; i--) begin
          if (shadow_table[i] == w_value) begin
            r.found = 1'b1;
            at = i;
            r.position = at[POS_W-1:0];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no word outstanding: found %0b position %0d status %0b",
                   $time, found, position, status);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (found !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, found);
            mismatches++;
          end
          if (position !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position, position);
            mismatches++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0b actual %0b", $time, want.status, status);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_word(op, value));
        accepted_cnt++;
      end
    end
  end

  always @(negedge clk) begin
    word_t w;
    if (rst) begin
      start <= 1'b0;
      op <= OP_CLEAR;
      value <= '0;
    end else if (start && accepted_cnt != issued_cnt) begin
    end else if (pending_words.size() > 0 && $urandom_range(99) >= pending_words[0].gap_pct) begin
      w = pending_words.pop_front();
      start <= 1'b1;
      op <= w.op;
      value <= w.value;
      issued_cnt++;
    end else begin
      start <= 1'b0;
    end
  end

  task automatic queue_word(logic [1:0] w_op, logic signed [DATA_W-1:0] w_value);
    word_t w;
    w.op = w_op;
    w.value = w_value;
    case ((queued_cnt / 130) % 4)
      1: w.gap_pct = 65;
      2: w.gap_pct = 6;
      3: w.gap_pct = 65;
      default: w.gap_pct = 0;
    endcase
    pending_words.push_back(w);
    queued_cnt++;
  endtask

  function automatic logic signed [DATA_W-1:0] draw_value(int mode);
    logic signed [DATA_W-1:0] v;
    case (mode)
      0: v = $urandom_range(16) - 8;
      1: v = $urandom;
      default: begin
        case ($urandom_range(4))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = 0;
          3: v = -1;
          default: v = $urandom;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin
    logic signed [DATA_W-1:0] kept[$];
    logic signed [DATA_W-1:0] v;
    int                       fill;
    int                       mode;
    rst = 1'b1;
    queued_cnt = 0;

    queue_word(OP_SEARCH, 0);
    queue_word(OP_UNUSED, 32'sh7fff_ffff);
    queue_word(OP_INSERT, 32'sh7fff_ffff);
    queue_word(OP_INSERT, 32'sh8000_0000);
    queue_word(OP_INSERT, 0);
    queue_word(OP_INSERT, -1);
    queue_word(OP_INSERT, 0);
    queue_word(OP_INSERT, 0);
    queue_word(OP_SEARCH, 0);
    queue_word(OP_SEARCH, 32'sh7fff_ffff);
    queue_word(OP_SEARCH, 32'sh8000_0000);
    queue_word(OP_SEARCH, -1);
    queue_word(OP_SEARCH, 5);
    queue_word(OP_SEARCH, 32'sh7fff_fffe);
    queue_word(OP_SEARCH, 32'sh8000_0001);
    queue_word(OP_UNUSED, 0);
    queue_word(OP_SEARCH, 0);
    queue_word(OP_CLEAR, -1);
    queue_word(OP_SEARCH, 0);
    queue_word(OP_INSERT, 1);
    queue_word(OP_SEARCH, 1);
    queue_word(OP_CLEAR, 0);

    while (queued_cnt < RANDOM_WORDS + 22) begin
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(1, 4)) queue_word(2'($urandom_range(3)), $urandom);
      end else begin
        if ($urandom_range(3) != 0) queue_word(OP_CLEAR, $urandom);
        fill = ($urandom_range(3) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 20);
        mode = $urandom_range(2);
        kept.delete();
        repeat (fill) begin
          v = draw_value(mode);
          queue_word(OP_INSERT, v);
          kept.push_back(v);
          if ($urandom_range(2) == 0) begin
            queue_word(OP_SEARCH, ($urandom_range(1) == 0) ?
                       kept[$urandom_range(kept.size() - 1)] : draw_value(mode));
          end
        end
        repeat ($urandom_range(2, 8)) begin
          queue_word(OP_SEARCH, ($urandom_range(2) != 0) ?
                     kept[$urandom_range(kept.size() - 1)] : draw_value(mode));
        end
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_words.size() > 0 || issued_cnt != accepted_cnt ||
           expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[sorted_table_binary_search] OK");
    end else begin
      $display("[sorted_table_binary_search] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[sorted_table_binary_search] ERROR");
    $finish;
  end

endmodule
